[rtl/radix_trie_key_value_map_macros.svh]
// Assertion macros shared by the radix trie map design.
`ifndef RADIX_TRIE_KEY_VALUE_MAP_MACROS_SVH
`define RADIX_TRIE_KEY_VALUE_MAP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define RTKV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define RTKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rtkv_pkg.sv]
// Package with the constants, codes and types of the radix trie map.
`timescale 1ns / 1ps
package rtkv_pkg;
    localparam int NODES    = 512;
    localparam int NODE_W   = $clog2(NODES);
    localparam int NIB_W    = 4;
    localparam int FANOUT   = 16;
    localparam int SLOT_AW  = NODE_W + NIB_W;
    localparam int CNT_W    = NODE_W + 1;
    localparam int LEVELS   = 7;
    localparam int LVL_W    = 3;
    localparam int SLOT_W   = 33;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_ABSENT = 2'd1,
        STS_FULL   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRD,
        ST_WEV,
        ST_ARD,
        ST_AWR,
        ST_LEAF,
        ST_SRD,
        ST_SEV,
        ST_FREE,
        ST_DONE
    } t_state;

    function automatic logic [NIB_W-1:0] nib_of(input logic [31:0] key,
                                                input logic [LVL_W-1:0] lvl);
        nib_of = key[{lvl, 2'b00} +: NIB_W];
    endfunction
endpackage

[rtl/rtkv_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module rtkv_ram #(
    parameter int P_W  = 33,
    parameter int P_AW = 13
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [P_AW-1:0] i_waddr,
    input  logic [P_W-1:0]  i_wdata,
    input  logic [P_AW-1:0] i_raddr,
    output logic [P_W-1:0]  o_rdata
);
    logic [P_W-1:0] r_mem [0:(2**P_AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/radix_trie_key_value_map.sv]
// A get, a delete of an absent key or a set of an existing key gives its result after the walk.
// A set that allocates nodes replaces the rest of the walk with an allocation read and write per new node.
// A delete also scans the nodes on its path from the leaf upward and frees each one it finds empty.
// One request is in flight at a time; a new one is taken only after the last result is loaded for output.
// Reset is synchronous; afterwards a clearing pass over every slot address empties the slot RAM
// and refills the free node stack, and no request is taken until it ends.
`timescale 1ns / 1ps
`include "radix_trie_key_value_map_macros.svh"
module radix_trie_key_value_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_lookup_key,
    input  logic signed [31:0] i_write_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value
);
    import rtkv_pkg::*;

    t_state              r_state, n_state;
    t_opcode             r_op, n_op;
    logic [31:0]         r_key, n_key;
    logic [31:0]         r_val, n_val;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [NODE_W-1:0]   r_path [0:LEVELS];
    logic [NODE_W-1:0]   n_path [0:LEVELS];
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [NIB_W-1:0]    r_idx, n_idx;
    logic [SLOT_AW-1:0]  r_clr, n_clr;
    t_status             r_sts, n_sts;
    logic [31:0]         r_rdv, n_rdv;
    logic                r_ov, n_ov;
    logic [1:0]          r_ost, n_ost;
    logic [31:0]         r_ordv, n_ordv;

    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]   slot_wdata, slot_q;
    logic                fl_we;
    logic [NODE_W-1:0]   fl_waddr, fl_raddr, fl_wdata, fl_q;
    logic                hit;
    logic [LVL_W-1:0]    lvl_m1;

    rtkv_ram #(.P_W(SLOT_W), .P_AW(SLOT_AW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_q)
    );

    rtkv_ram #(.P_W(NODE_W), .P_AW(NODE_W)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (fl_raddr),
        .o_rdata (fl_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cnt   <= CNT_W'(NODES - 1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_op   <= n_op;
        r_key  <= n_key;
        r_val  <= n_val;
        r_lvl  <= n_lvl;
        r_node <= n_node;
        r_path <= n_path;
        r_idx  <= n_idx;
        r_sts  <= n_sts;
        r_rdv  <= n_rdv;
        r_ost  <= n_ost;
        r_ordv <= n_ordv;
    end

    assign hit    = slot_q[SLOT_W-1] && (slot_q[31:NODE_W] == '0);
    assign lvl_m1 = r_lvl - LVL_W'(1);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_lvl      = r_lvl;
        n_node     = r_node;
        n_path     = r_path;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_sts      = r_sts;
        n_rdv      = r_rdv;
        n_ov       = r_ov && !i_ready;
        n_ost      = r_ost;
        n_ordv     = r_ordv;
        o_ready    = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = {r_node, nib_of(r_key, r_lvl)};
        slot_wdata = '0;
        slot_raddr = {r_node, nib_of(r_key, r_lvl)};
        fl_we      = 1'b0;
        fl_waddr   = r_cnt[NODE_W-1:0];
        fl_wdata   = r_path[r_lvl];
        fl_raddr   = NODE_W'(r_cnt - CNT_W'(1));
        case (r_state)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                fl_we      = (r_clr < SLOT_AW'(NODES));
                fl_waddr   = r_clr[NODE_W-1:0];
                fl_wdata   = NODE_W'(NODES - 1) - r_clr[NODE_W-1:0];
                n_clr      = r_clr + SLOT_AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op      = t_opcode'(i_opcode);
                    n_key     = i_lookup_key;
                    n_val     = i_write_value;
                    n_lvl     = '0;
                    n_node    = '0;
                    n_path[0] = '0;
                    n_idx     = '0;
                    n_sts     = STS_OK;
                    n_rdv     = '0;
                    n_state   = (t_opcode'(i_opcode) == OP_NOP) ? ST_DONE : ST_WRD;
                end
            end
            ST_WRD: begin
                n_state = ST_WEV;
            end
            ST_WEV: begin
                if (r_lvl == LVL_W'(LEVELS)) begin
                    case (r_op)
                        OP_GET: begin
                            if (slot_q[SLOT_W-1]) begin
                                n_rdv = slot_q[31:0];
                            end else begin
                                n_sts = STS_ABSENT;
                            end
                            n_state = ST_DONE;
                        end
                        OP_SET: begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, r_val};
                            n_state    = ST_DONE;
                        end
                        default: begin
                            if (slot_q[SLOT_W-1]) begin
                                slot_we = 1'b1;
                                n_idx   = '0;
                                n_state = ST_SRD;
                            end else begin
                                n_sts   = STS_ABSENT;
                                n_state = ST_DONE;
                            end
                        end
                    endcase
                end else if (hit) begin
                    n_node                 = slot_q[NODE_W-1:0];
                    n_path[r_lvl + LVL_W'(1)] = slot_q[NODE_W-1:0];
                    n_lvl                  = r_lvl + LVL_W'(1);
                    n_state                = ST_WRD;
                end else if (r_op == OP_SET) begin
                    if (CNT_W'(LEVELS - 0) - CNT_W'(r_lvl) > r_cnt) begin
                        n_sts   = STS_FULL;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ARD;
                    end
                end else begin
                    n_sts   = STS_ABSENT;
                    n_state = ST_DONE;
                end
            end
            ST_ARD: begin
                n_state = ST_AWR;
            end
            ST_AWR: begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, (32 - NODE_W)'(0), fl_q};
                n_node     = fl_q;
                n_cnt      = r_cnt - CNT_W'(1);
                n_lvl      = r_lvl + LVL_W'(1);
                n_state    = (r_lvl == LVL_W'(LEVELS - 1)) ? ST_LEAF : ST_ARD;
            end
            ST_LEAF: begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, r_val};
                n_state    = ST_DONE;
            end
            ST_SRD: begin
                slot_raddr = {r_path[r_lvl], r_idx};
                n_state    = ST_SEV;
            end
            ST_SEV: begin
                if (slot_q[SLOT_W-1]) begin
                    n_state = ST_DONE;
                end else if (r_idx == NIB_W'(FANOUT - 1)) begin
                    n_state = ST_FREE;
                end else begin
                    n_idx   = r_idx + NIB_W'(1);
                    n_state = ST_SRD;
                end
            end
            ST_FREE: begin
                slot_we    = 1'b1;
                slot_waddr = {r_path[lvl_m1], nib_of(r_key, lvl_m1)};
                if (r_cnt < CNT_W'(NODES)) begin
                    fl_we = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_lvl   = lvl_m1;
                n_idx   = '0;
                n_state = (r_lvl == LVL_W'(1)) ? ST_DONE : ST_SRD;
            end
            ST_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_ost   = r_sts;
                    n_ordv  = r_rdv;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_ov;
    assign o_status     = r_ost;
    assign o_read_value = r_ordv;

    `RTKV_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= CNT_W'(NODES - 1), "free count out of range")
    `RTKV_ASSERT_NEXT(a_accept_busy, i_valid && o_ready, r_state != ST_IDLE, "accept not busy")
    `RTKV_ASSERT_IMP(a_leaf_level, r_state == ST_LEAF, r_lvl == LVL_W'(LEVELS), "leaf level")
    `RTKV_ASSERT_IMP(a_free_level, r_state == ST_FREE, r_lvl != '0, "free at root")
endmodule

[dv/tb_radix_trie_key_value_map.sv]
// Self-checking testbench for the radix trie key-value map with a behavioral trie predictor.
`timescale 1ns / 1ps
module tb_radix_trie_key_value_map;
    import rtkv_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_opcode = 2'd0;
    logic [31:0]        i_lookup_key = 32'd0;
    logic signed [31:0] i_write_value = 32'sd0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;

    radix_trie_key_value_map uut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value;
    } t_answer;

    typedef struct {
        t_opcode            op;
        logic [31:0]        key;
        logic signed [31:0] value;
        logic               typed;
        t_answer            answer;
    } t_row;

    logic [32:0]       trie_slots [NODES*FANOUT];
    logic [NODE_W-1:0] spare_nodes [NODES];
    int                spare_count;
    t_answer           pending_answers [$];
    int                error_count = 0;
    int                answers_seen = 0;
    int                quiet_cycles = 0;
    logic              hold_off = 1'b0;
    logic              calm = 1'b0;
    int                op_tally [4];
    logic [31:0]       used_keys [$];

    function automatic int slot_index(int node, logic [31:0] key, int lvl);
        return node * FANOUT + int'(key[lvl*4 +: 4]);
    endfunction

    function automatic t_answer trie_apply(t_opcode op, logic [31:0] key,
                                           logic signed [31:0] value);
        int      path [LEVELS+1];
        int      reached;
        int      leaf;
        int      fresh;
        bit      empty;
        t_answer ans;
        ans = '{STS_OK, 32'sd0};
        path[0] = 0;
        reached = LEVELS;
        for (int d = 0; d < LEVELS; d++) begin
            if (!trie_slots[slot_index(path[d], key, d)][32]) begin
                reached = d;
                break;
            end
            path[d+1] = int'(trie_slots[slot_index(path[d], key, d)][31:0]);
        end
        if (op == OP_NOP) return ans;
        if (op == OP_SET) begin
            if (LEVELS - reached > spare_count) begin
                ans.status = STS_FULL;
                return ans;
            end
            for (int d = reached; d < LEVELS; d++) begin
                spare_count--;
                fresh = spare_nodes[spare_count];
                for (int i = 0; i < FANOUT; i++) trie_slots[fresh*FANOUT+i] = '0;
                trie_slots[slot_index(path[d], key, d)] = {1'b1, 32'(fresh)};
                path[d+1] = fresh;
            end
            trie_slots[slot_index(path[LEVELS], key, LEVELS)] = {1'b1, value};
            return ans;
        end
        if (reached < LEVELS) begin
            ans.status = STS_ABSENT;
            return ans;
        end
        leaf = slot_index(path[LEVELS], key, LEVELS);
        if (!trie_slots[leaf][32]) begin
            ans.status = STS_ABSENT;
            return ans;
        end
        if (op == OP_GET) begin
            ans.value = trie_slots[leaf][31:0];
            return ans;
        end
        trie_slots[leaf] = '0;
        for (int d = LEVELS; d >= 1; d--) begin
            empty = 1'b1;
            for (int i = 0; i < FANOUT; i++)
                if (trie_slots[path[d]*FANOUT+i][32]) empty = 1'b0;
            if (!empty) break;
            trie_slots[slot_index(path[d-1], key, d-1)] = '0;
            if (spare_count < NODES) begin
                spare_nodes[spare_count] = NODE_W'(path[d]);
                spare_count++;
            end
        end
        return ans;
    endfunction

    task automatic send_request(t_opcode op, logic [31:0] key, logic signed [31:0] value,
                                logic typed, t_answer typed_answer);
        t_answer predicted;
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_lookup_key <= key;
        i_write_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = trie_apply(op, key, value);
        if (typed && predicted != typed_answer) begin
            $error("typed row disagrees with predictor: status %0d/%0d value %0d/%0d",
                   typed_answer.status, predicted.status, typed_answer.value, predicted.value);
            error_count++;
        end
        pending_answers.push_back(predicted);
        op_tally[op]++;
        if (op == OP_SET && used_keys.size() < 400) used_keys.push_back(key);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        logic [31:0] k;
        r = $urandom_range(99);
        if (used_keys.size() > 0 && r < 45) return used_keys[$urandom_range(used_keys.size()-1)];
        if (used_keys.size() > 0 && r < 75) begin
            k = used_keys[$urandom_range(used_keys.size()-1)];
            k[$urandom_range(31)] ^= 1'b1;
            return k;
        end
        if (r < 85) return {4'($urandom_range(15)), 4'h0, 16'h0, 8'($urandom_range(255))};
        return $urandom;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !hold_off && (calm || $urandom_range(99) >= 13);
            if (o_valid && i_ready) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    $error("unexpected result: status %0d read_value %0d", o_status, o_read_value);
                    error_count++;
                end else begin
                    if (o_status !== pending_answers[0].status) begin
                        $error("status: expected %0d actual %0d",
                               pending_answers[0].status, o_status);
                        error_count++;
                    end
                    if (o_read_value !== pending_answers[0].value) begin
                        $error("read_value: expected %0d actual %0d",
                               pending_answers[0].value, o_read_value);
                        error_count++;
                    end
                    void'(pending_answers.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row              rows [$];
        for (int i = 0; i < NODES*FANOUT; i++) trie_slots[i] = '0;
        for (int i = 0; i < NODES - 1; i++) spare_nodes[i] = NODE_W'(NODES - 1 - i);
        spare_count = NODES - 1;
        rows = '{
            '{OP_GET, 32'h0000_0000, 32'sd0, 1'b1, '{STS_ABSENT, 32'sd0}},
            '{OP_DEL, 32'hFFFF_FFFF, 32'sd0, 1'b1, '{STS_ABSENT, 32'sd0}},
            '{OP_NOP, 32'h1234_5678, 32'sd7, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_SET, 32'h0000_0000, 32'h8000_0000, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_GET, 32'h0000_0000, 32'sd0, 1'b1, '{STS_OK, 32'h8000_0000}},
            '{OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_GET, 32'hFFFF_FFFF, 32'sd0, 1'b1, '{STS_OK, 32'h7FFF_FFFF}},
            '{OP_SET, 32'hFFFF_FFFF, -32'sd1, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_GET, 32'hFFFF_FFFF, 32'sd0, 1'b1, '{STS_OK, -32'sd1}},
            '{OP_GET, 32'h0FFF_FFFF, 32'sd0, 1'b1, '{STS_ABSENT, 32'sd0}},
            '{OP_SET, 32'h1000_0000, 32'sd5, 1'b0, '{STS_OK, 32'sd0}},
            '{OP_GET, 32'h0000_0000, 32'sd0, 1'b0, '{STS_OK, 32'sd0}},
            '{OP_DEL, 32'h0000_0000, 32'sd0, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_GET, 32'h1000_0000, 32'sd0, 1'b1, '{STS_OK, 32'sd5}},
            '{OP_DEL, 32'h0000_0000, 32'sd0, 1'b1, '{STS_ABSENT, 32'sd0}},
            '{OP_DEL, 32'h1000_0000, 32'sd0, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_DEL, 32'hFFFF_FFFF, 32'sd0, 1'b1, '{STS_OK, 32'sd0}},
            '{OP_NOP, 32'hFFFF_FFFF, -32'sd1, 1'b1, '{STS_OK, 32'sd0}}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) send_request(rows[i].op, rows[i].key, rows[i].value,
                                       rows[i].typed, rows[i].answer);
        // Exhaust the node pool with keys that share few nodes below the root.
        for (int i = 0; i < 100; i++)
            send_request(OP_SET, $urandom & 32'hFFFF_FFF0 | 32'(i % 16) | 32'(i << 4),
                         $urandom, 1'b0, '{STS_OK, 32'sd0});
        for (int i = 0; i < 80; i++) begin
            if (i == 20) hold_off = 1'b1;
            if (i == 20) fork begin repeat (300) @(posedge i_clk); hold_off = 1'b0; end join_none
            if (i == 40) calm = 1'b1;
            if (i == 70) calm = 1'b0;
            send_request(t_opcode'($urandom_range(2)), pick_key(), $urandom, 1'b0,
                         '{STS_OK, 32'sd0});
        end
        for (int i = 0; i < 1500; i++) begin
            if (i == 700) calm = 1'b1;
            if (i == 900) calm = 1'b0;
            send_request(t_opcode'($urandom_range(99) < 3 ? 3 : $urandom_range(2)),
                         pick_key(), $urandom, 1'b0, '{STS_OK, 32'sd0});
        end
        i_valid <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d gets, %0d sets, %0d deletes, %0d no-ops; %0d results checked.",
                 op_tally[0], op_tally[1], op_tally[2], op_tally[3], answers_seen);
        $display("Pool exhaustion, key extremes and a long output stall were exercised.");
        if (error_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
